@@ hw/rtl/pcxrle_pkg.sv @@
// Shared types and constants for the PCX run-length pixel decoder.
// Used by the controller, the datapath and the top level.
package pcxrle_pkg;

    // Field widths fixed by the byte format and the pixel counters
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int TOTAL_W = 21;
    localparam int INDEX_W = 20;

    // Count byte: both top bits set, run length in the low six bits
    localparam logic [BYTE_W-1:0] CNT_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] LEN_MASK = 8'h3F;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;    // output register empty or being taken now
        logic full;        // image already complete
        logic pending;     // count byte seen, value byte due
        logic count_byte;  // current byte is a run count (and not final)
        logic len_zero;    // clipped run length is zero
        logic len_one;     // clipped run length is one
        logic left_one;    // one run pixel left to emit
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic emit_in;       // emit one pixel from the input byte
        logic emit_last;     // last-of-burst flag for emit_in
        logic run_start;     // latch run value and remaining count
        logic emit_run;      // emit one pixel from the run registers
        logic set_pending;   // latch count byte
        logic clear_pending; // drop pending run
    } t_cmd;

endpackage

@@ hw/rtl/pcx_rle_pixel_decoder.sv @@
// PCX run-length pixel decoder, top level.
// The first pixel word of an accepted byte is registered and valid in the cycle after.
// Throughput: literal bytes one per cycle unless the output stalls; a run holds
// input after its value byte, one run-counter pixel per cycle unless stalled.
// Reset (synchronous, active low) clears counters and pending run, total = 1.
module pcx_rle_pixel_decoder #(
    parameter int unsigned MAX_PIXELS = 1048576
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcxrle_pkg::TOTAL_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pcxrle_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                           i_final_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pcxrle_pkg::BYTE_W-1:0]  o_pixel_value,
    output logic [pcxrle_pkg::INDEX_W-1:0] o_pixel_index,
    output logic                           o_last_of_burst,
    output logic                           o_image_full
);

    pcxrle_pkg::t_status status;
    pcxrle_pkg::t_cmd    cmd;

    // Sequencer
    pcxrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Counters, run registers and output word
    pcxrle_dpath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_data_byte     (i_data_byte),
        .i_final_byte    (i_final_byte),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_pixel_value   (o_pixel_value),
        .o_pixel_index   (o_pixel_index),
        .o_last_of_burst (o_last_of_burst),
        .o_image_full    (o_image_full)
    );

endmodule

@@ hw/rtl/pcxrle_ctrl.sv @@
// Controller for the PCX run-length pixel decoder.
// Depends on pcxrle_pkg for the command and status structs.
module pcxrle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pcxrle_pkg::t_status i_status,
    output logic               o_in_stall,
    output pcxrle_pkg::t_cmd   o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // Input is taken only between runs and when the output slot frees up
    assign o_in_stall = (r_state == ST_RUN) || !i_status.out_free;
    assign accept     = i_in_valid && !o_in_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_status.full) begin
                        o_cmd.clear_pending = 1'b1;
                    end else if (i_status.pending) begin
                        o_cmd.clear_pending = 1'b1;
                        if (!i_status.len_zero) begin
                            o_cmd.emit_in   = 1'b1;
                            o_cmd.emit_last = i_status.len_one;
                            if (!i_status.len_one) begin
                                o_cmd.run_start = 1'b1;
                                n_state         = ST_RUN;
                            end
                        end
                    end else if (i_status.count_byte) begin
                        o_cmd.set_pending = 1'b1;
                    end else begin
                        o_cmd.emit_in   = 1'b1;
                        o_cmd.emit_last = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_run = 1'b1;
                    if (i_status.left_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/pcxrle_dpath.sv @@
// Datapath for the PCX run-length pixel decoder: counters, run registers,
// pixel limit and the output register. Depends on pcxrle_pkg.
module pcxrle_dpath #(
    parameter int unsigned MAX_PIXELS = 1048576
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcxrle_pkg::TOTAL_W-1:0]      i_cfg_wdata,
    input  logic [pcxrle_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                                i_final_byte,
    input  logic                                i_out_stall,
    input  pcxrle_pkg::t_cmd                    i_cmd,
    output pcxrle_pkg::t_status                 o_status,
    output logic                                o_out_valid,
    output logic [pcxrle_pkg::BYTE_W-1:0]       o_pixel_value,
    output logic [pcxrle_pkg::INDEX_W-1:0]      o_pixel_index,
    output logic                                o_last_of_burst,
    output logic                                o_image_full
);

    // Limit clipped to what the total register can express
    localparam int unsigned TOTAL_MAX = (1 << pcxrle_pkg::TOTAL_W) - 1;
    localparam int unsigned MAX_CLIP  = (MAX_PIXELS > TOTAL_MAX) ? TOTAL_MAX : MAX_PIXELS;
    localparam logic [pcxrle_pkg::TOTAL_W-1:0] LIM_CAP = MAX_CLIP[pcxrle_pkg::TOTAL_W-1:0];

    logic [pcxrle_pkg::TOTAL_W-1:0] r_pixel_total;
    logic [pcxrle_pkg::TOTAL_W-1:0] r_done;
    logic                           r_pending;
    logic [pcxrle_pkg::LEN_W-1:0]   r_count;
    logic [pcxrle_pkg::LEN_W-1:0]   r_left;
    logic [pcxrle_pkg::BYTE_W-1:0]  r_run_val;
    logic                           r_out_valid;
    logic [pcxrle_pkg::BYTE_W-1:0]  r_out_value;
    logic [pcxrle_pkg::INDEX_W-1:0] r_out_index;
    logic                           r_out_last;
    logic                           r_out_full;

    logic [pcxrle_pkg::TOTAL_W-1:0] lim;
    logic [pcxrle_pkg::TOTAL_W-1:0] room;
    logic [pcxrle_pkg::TOTAL_W-1:0] done_inc;
    logic [pcxrle_pkg::LEN_W-1:0]   run_len;
    logic [pcxrle_pkg::LEN_W-1:0]   byte_len;
    logic                           emit;

    // Effective limit, room left, clipped run length
    assign lim      = (r_pixel_total > LIM_CAP) ? LIM_CAP : r_pixel_total;
    assign room     = lim - r_done;
    assign done_inc = r_done + {{(pcxrle_pkg::TOTAL_W-1){1'b0}}, 1'b1};
    assign run_len  = ({{(pcxrle_pkg::TOTAL_W-pcxrle_pkg::LEN_W){1'b0}}, r_count} > room)
                      ? room[pcxrle_pkg::LEN_W-1:0] : r_count;
    assign byte_len = i_data_byte[pcxrle_pkg::LEN_W-1:0]
                      & pcxrle_pkg::LEN_MASK[pcxrle_pkg::LEN_W-1:0];
    assign emit     = i_cmd.emit_in || i_cmd.emit_run;

    // Status to controller
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.full       = (r_done >= lim);
    assign o_status.pending    = r_pending;
    assign o_status.count_byte = ((i_data_byte & pcxrle_pkg::CNT_MARK) == pcxrle_pkg::CNT_MARK)
                                 && !i_final_byte;
    assign o_status.len_zero   = (run_len == '0);
    assign o_status.len_one    = (run_len == {{(pcxrle_pkg::LEN_W-1){1'b0}}, 1'b1});
    assign o_status.left_one   = (r_left == {{(pcxrle_pkg::LEN_W-1){1'b0}}, 1'b1});

    // Config register, counters and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_total <= {{(pcxrle_pkg::TOTAL_W-1){1'b0}}, 1'b1};
            r_done        <= '0;
            r_pending     <= 1'b0;
            r_count       <= '0;
            r_left        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pixel_total <= i_cfg_wdata;
            end
            if (emit) begin
                r_done <= done_inc;
            end
            if (i_cmd.set_pending) begin
                r_pending <= 1'b1;
                r_count   <= byte_len;
            end else if (i_cmd.clear_pending) begin
                r_pending <= 1'b0;
            end
            if (i_cmd.run_start) begin
                r_left <= run_len - {{(pcxrle_pkg::LEN_W-1){1'b0}}, 1'b1};
            end else if (i_cmd.emit_run) begin
                r_left <= r_left - {{(pcxrle_pkg::LEN_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // Run value is payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_run_val <= i_data_byte;
        end
    end

    // Output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= i_cmd.emit_run ? r_run_val : i_data_byte;
            r_out_index <= r_done[pcxrle_pkg::INDEX_W-1:0];
            r_out_last  <= i_cmd.emit_run ? o_status.left_one : i_cmd.emit_last;
            r_out_full  <= (done_inc == lim);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_value   = r_out_value;
    assign o_pixel_index   = r_out_index;
    assign o_last_of_burst = r_out_last;
    assign o_image_full    = r_out_full;

endmodule

@@ hw/rtl/pcxrle_checker.sv @@
// Port-level checks for the PCX run-length pixel decoder, bound to the top.
// Depends on pcxrle_pkg for field widths.
module pcxrle_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [pcxrle_pkg::INDEX_W-1:0] o_pixel_index,
    input logic                           o_last_of_burst,
    input logic                           o_image_full
);

    logic out_take;
    assign out_take = o_out_valid && !i_out_stall;

    // A stalled output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // No input is taken while the output word is blocked
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input accepted while output blocked");

    // Inside a burst the next pixel follows at once with the next index
    a_burst_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !o_last_of_burst |=>
            o_out_valid && (o_pixel_index == ($past(o_pixel_index) + 1'b1)))
        else $error("burst pixel missing or out of order");

    // Nothing follows the pixel that fills the image
    a_full_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && o_image_full |=> !o_out_valid)
        else $error("pixel emitted after image full");

endmodule

bind pcx_rle_pixel_decoder pcxrle_checker u_pcxrle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pixel_index   (o_pixel_index),
    .o_last_of_burst (o_last_of_burst),
    .o_image_full    (o_image_full)
);
